// ----- design/text_console_cursor_engine_defines.svh -----
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcce assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcce assertion failed");

`endif

// ----- design/tcce_pkg.sv -----
`default_nettype none

package tcce_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_PRINT_MAX = 8'h7F;

  localparam int TAB_STEP = 8;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TAB_ORIGIN = 1'b0;
  localparam cfg_idx_t CFG_TEXT_ATTR  = 1'b1;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int RESULT_W    = 43;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_code;
    logic [6:0] set_col;
    logic [4:0] set_row;
  } item_t;

  // Last member lands in the lowest bits.
  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       clear_screen;
    logic       scroll_up;
    logic [7:0] write_attr;
    logic [7:0] write_char;
    logic [4:0] write_row;
    logic [6:0] write_col;
    logic       write_valid;
  } result_t;

endpackage

`default_nettype wire

// ----- design/tcce_in_reg.sv -----
`default_nettype none

module tcce_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire tcce_pkg::item_t in_item,
  input  wire logic            advance,
  output logic                 item_valid,
  output tcce_pkg::item_t      item
);

  logic            valid_r;
  tcce_pkg::item_t item_r;

  // Holds one transaction; refills in the cycle it drains.
  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcce_cursor.sv -----
`default_nettype none

module tcce_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire tcce_pkg::cfg_idx_t cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               step,
  input  wire tcce_pkg::item_t    item,
  output tcce_pkg::result_t       result
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int EW = CW + 4;
  localparam int RX = RW + 1;

  localparam logic [EW-1:0] COL_LIMIT = EW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RX-1:0] ROW_LIMIT = RX'(ROWS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [EW-1:0] TAB_MASK  = ~EW'(tcce_pkg::TAB_STEP - 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [2:0]    tab_origin_r;
  logic [7:0]    attr_r;

  logic [EW-1:0] col_w;
  logic [RX-1:0] row_w;
  logic [EW-1:0] tab_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_origin_r <= '0;
      attr_r       <= tcce_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcce_pkg::CFG_TAB_ORIGIN: tab_origin_r <= cfg_wdata[2:0];
        tcce_pkg::CFG_TEXT_ATTR:  attr_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign tab_sum = EW'(col_r) + EW'(tcce_pkg::TAB_STEP) - EW'(tab_origin_r);

  always_comb begin
    result  = '0;
    col_nxt = col_r;
    row_nxt = row_r;
    col_w   = EW'(col_r);
    row_w   = RX'(row_r);
    unique case (item.operation)
      tcce_pkg::OP_WRITE: begin
        if (item.char_code == tcce_pkg::CH_BS) begin
          // At column zero wrap to the end of the row above, pinned on the top row.
          if (col_r != '0) begin
            col_w = EW'(col_r) - EW'(1);
          end else begin
            col_w = EW'(COL_LAST);
            if (row_r != '0) begin
              row_w = RX'(row_r) - RX'(1);
            end
          end
          result.write_valid = 1'b1;
          result.write_col   = 7'(col_w);
          result.write_row   = 5'(row_w);
          result.write_char  = tcce_pkg::CH_SPACE;
          result.write_attr  = attr_r;
        end else if (item.char_code == tcce_pkg::CH_TAB) begin
          col_w = (tab_sum & TAB_MASK) + EW'(tab_origin_r);
        end else if (item.char_code == tcce_pkg::CH_CR) begin
          col_w = '0;
        end else if (item.char_code == tcce_pkg::CH_LF) begin
          col_w = '0;
          row_w = row_w + RX'(1);
        end else if (item.char_code >= tcce_pkg::CH_SPACE &&
                     item.char_code <= tcce_pkg::CH_PRINT_MAX) begin
          result.write_valid = 1'b1;
          result.write_col   = 7'(col_r);
          result.write_row   = 5'(row_r);
          result.write_char  = item.char_code;
          result.write_attr  = attr_r;
          col_w = col_w + EW'(1);
        end
        if (col_w >= COL_LIMIT) begin
          col_w = '0;
          row_w = row_w + RX'(1);
        end
        if (row_w >= ROW_LIMIT) begin
          result.scroll_up = 1'b1;
          row_w = RX'(ROW_LAST);
        end
        col_nxt = CW'(col_w);
        row_nxt = RW'(row_w);
      end
      tcce_pkg::OP_SET: begin
        col_nxt = (item.set_col > 7'(COLUMNS - 1)) ? COL_LAST : CW'(item.set_col);
        row_nxt = (32'(item.set_row) > 32'(ROWS - 1)) ? ROW_LAST : RW'(item.set_row);
      end
      tcce_pkg::OP_CLEAR: begin
        col_nxt = '0;
        row_nxt = '0;
        result.clear_screen = 1'b1;
      end
      default: ;
    endcase
    result.cursor_col = 7'(col_nxt);
    result.cursor_row = 5'(row_nxt);
  end

endmodule

`default_nettype wire

// ----- design/text_console_cursor_engine.sv -----
// Stages: the input register, then the result register that drives out_tvalid.
// Throughput: one transaction per cycle unless out_tready holds the output; the cursor update is
//   one pass of logic from the input register into the cursor and result registers.
// Reset (rst_n low, synchronous): cursor homed to column 0, row 0,
//   tab_origin 0, text_attr 0x07, both stage valids cleared.
`default_nettype none

module text_console_cursor_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // char_code[7:0], set_col[14:8], set_row[19:15], zero fill
  input  wire logic [23:0] in_tdata,
  // operation[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // write_valid[0], write_col[7:1], write_row[12:8], write_char[20:13],
  // write_attr[28:21], scroll_up[29], clear_screen[30], cursor_col[37:31],
  // cursor_row[42:38], zero fill
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  tcce_pkg::item_t   in_item;
  tcce_pkg::item_t   item;
  tcce_pkg::result_t result;
  tcce_pkg::result_t res_r;
  logic              item_valid;
  logic              advance;
  logic              step;
  logic              out_valid_r;

  assign in_item.operation = tcce_pkg::op_t'(in_tuser);
  assign in_item.char_code = in_tdata[7:0];
  assign in_item.set_col   = in_tdata[14:8];
  assign in_item.set_row   = in_tdata[19:15];

  assign advance = !out_valid_r || out_tready;
  assign step    = item_valid && advance;

  tcce_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tcce_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(tcce_pkg::OUT_TDATA_W - tcce_pkg::RESULT_W)'(0), res_r};

endmodule

`default_nettype wire

// ----- design/tcce_checker.sv -----
`default_nettype none
`include "text_console_cursor_engine_defines.svh"

module tcce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  `TCCE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `TCCE_ASSERT_IMP(a_clear_homes, clk, rst_n, out_tvalid && out_tdata[30], out_tdata[42:31] == 12'd0 && !out_tdata[29] && !out_tdata[0])
  `TCCE_ASSERT_IMP(a_cursor_range, clk, rst_n, out_tvalid, out_tdata[37:31] <= 7'(COLUMNS - 1) && 32'(out_tdata[42:38]) <= 32'(ROWS - 1))
  `TCCE_ASSERT_IMP(a_no_write_cell, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[28:1] == 28'd0)

endmodule

bind text_console_cursor_engine tcce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  // Operation code that the block has to ignore.
  localparam logic [1:0] OP_NONE = 2'd3;

  class cursor_tracker;
    int                cur_col;
    int                cur_row;
    int                tab_org;
    int                attr;
    int                errors;
    tcce_pkg::result_t expected_results[$];

    function new();
      cur_col = 0;
      cur_row = 0;
      tab_org = 0;
      attr    = int'(tcce_pkg::ATTR_RESET);
      errors  = 0;
    endfunction

    function void set_register(tcce_pkg::cfg_idx_t idx, logic [7:0] val);
      if (idx == tcce_pkg::CFG_TAB_ORIGIN) tab_org = int'(val[2:0]);
      else attr = int'(val);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function tcce_pkg::result_t predict_cursor(logic [1:0] op, logic [7:0] ch,
                                               logic [6:0] scol, logic [4:0] srow);
      tcce_pkg::result_t r;
      int col;
      int row;
      r   = '0;
      col = cur_col;
      row = cur_row;
      case (op)
        tcce_pkg::OP_WRITE: begin
          if (ch == tcce_pkg::CH_BS) begin
            if (col > 0) begin
              col--;
            end else begin
              // wrap to the end of the row above, row 0 stays put
              col = COLUMNS - 1;
              if (row > 0) row--;
            end
            r.write_valid = 1'b1;
            r.write_col   = 7'(col);
            r.write_row   = 5'(row);
            r.write_char  = tcce_pkg::CH_SPACE;
            r.write_attr  = 8'(attr);
          end else if (ch == tcce_pkg::CH_TAB) begin
            col = ((col + tcce_pkg::TAB_STEP - tab_org) & ~(tcce_pkg::TAB_STEP - 1))
                  + tab_org;
          end else if (ch == tcce_pkg::CH_CR) begin
            col = 0;
          end else if (ch == tcce_pkg::CH_LF) begin
            row++;
            col = 0;
          end else if (ch >= tcce_pkg::CH_SPACE && ch <= tcce_pkg::CH_PRINT_MAX) begin
            r.write_valid = 1'b1;
            r.write_col   = 7'(col);
            r.write_row   = 5'(row);
            r.write_char  = ch;
            r.write_attr  = 8'(attr);
            col++;
          end
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) begin
            r.scroll_up = 1'b1;
            row = ROWS - 1;
          end
        end
        tcce_pkg::OP_SET: begin
          col = (int'(scol) > COLUMNS - 1) ? COLUMNS - 1 : int'(scol);
          row = (int'(srow) > ROWS - 1) ? ROWS - 1 : int'(srow);
        end
        tcce_pkg::OP_CLEAR: begin
          col = 0;
          row = 0;
          r.clear_screen = 1'b1;
        end
        default: ;
      endcase
      cur_col = col;
      cur_row = row;
      r.cursor_col = 7'(col);
      r.cursor_row = 5'(row);
      return r;
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] ch,
                            logic [6:0] scol, logic [4:0] srow);
      expected_results.push_back(predict_cursor(op, ch, scol, srow));
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d",
                 $time, name, exp_val, act_val);
      end
    endfunction

    function void check_result(tcce_pkg::result_t got);
      tcce_pkg::result_t exp_r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("write_valid", int'(exp_r.write_valid), int'(got.write_valid));
      compare_field("write_col", int'(exp_r.write_col), int'(got.write_col));
      compare_field("write_row", int'(exp_r.write_row), int'(got.write_row));
      compare_field("write_char", int'(exp_r.write_char), int'(got.write_char));
      compare_field("write_attr", int'(exp_r.write_attr), int'(got.write_attr));
      compare_field("scroll_up", int'(exp_r.scroll_up), int'(got.scroll_up));
      compare_field("clear_screen", int'(exp_r.clear_screen), int'(got.clear_screen));
      compare_field("cursor_col", int'(exp_r.cursor_col), int'(got.cursor_col));
      compare_field("cursor_row", int'(exp_r.cursor_row), int'(got.cursor_row));
    endfunction
  endclass

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [23:0]        in_tdata    = '0;
  logic [1:0]         in_tuser    = '0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [47:0]        out_tdata;
  logic               cfg_wr_en   = 1'b0;
  tcce_pkg::cfg_idx_t cfg_index   = tcce_pkg::CFG_TAB_ORIGIN;
  logic [7:0]         cfg_wdata   = '0;

  logic        hold_off      = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  cursor_tracker tracker;

  text_console_cursor_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Result side: check on the sampled handshake, then pick next ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(tcce_pkg::result_t'(out_tdata[tcce_pkg::RESULT_W-1:0]));
    end
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic hold_receiver(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  task automatic send_item(logic [1:0] op, logic [7:0] ch, logic [6:0] scol,
                           logic [4:0] srow);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, srow, scol, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_item(op, ch, scol, srow);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(tcce_pkg::cfg_idx_t idx, logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic send_random();
    logic [1:0] op;
    logic [7:0] ch;
    logic [6:0] scol;
    logic [4:0] srow;
    int         pick;
    pick = int'($urandom_range(99));
    op   = tcce_pkg::OP_WRITE;
    ch   = 8'($urandom_range(255));
    scol = 7'($urandom_range(127));
    srow = 5'($urandom_range(31));
    if (pick < 60) begin
      ch = 8'($urandom_range(tcce_pkg::CH_PRINT_MAX, tcce_pkg::CH_SPACE));
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: ch = tcce_pkg::CH_BS;
        1: ch = tcce_pkg::CH_TAB;
        2: ch = tcce_pkg::CH_CR;
        default: ch = tcce_pkg::CH_LF;
      endcase
    end else if (pick < 85) begin
      // random byte, mostly ignored ones
    end else if (pick < 93) begin
      op = tcce_pkg::OP_SET;
      if ($urandom_range(1) != 0) begin
        scol = 7'($urandom_range(COLUMNS - 1));
        srow = 5'($urandom_range(ROWS - 1));
      end
    end else if (pick < 97) begin
      op = tcce_pkg::OP_CLEAR;
    end else begin
      op = OP_NONE;
    end
    send_item(op, ch, scol, srow);
  endtask

  task automatic run_phase(int count, int s_pct, int r_pct, logic [7:0] tab,
                           logic [7:0] attr);
    write_reg(tcce_pkg::CFG_TAB_ORIGIN, tab);
    write_reg(tcce_pkg::CFG_TEXT_ATTR, attr);
    send_idle_pct <= s_pct;
    recv_idle_pct <= r_pct;
    repeat (count) send_random();
    drain();
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct <= 8;
    recv_idle_pct <= 63;
    send_item(tcce_pkg::OP_WRITE, 8'h41, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_BS, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_BS, 7'd0, 5'd0);      // top-left backspace
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_SPACE, 7'd0, 5'd0);   // column wrap
    send_item(tcce_pkg::OP_SET, 8'h00, 7'd127, 5'd31);               // saturating set
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_PRINT_MAX, 7'd0, 5'd0); // wrap plus scroll
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_LF, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_TAB, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, 8'hFF, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, 8'h80, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, 8'h00, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, 8'h1F, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_CR, 7'd0, 5'd0);
    send_item(OP_NONE, 8'h5A, 7'd5, 5'd5);
    send_item(tcce_pkg::OP_SET, 8'h00, 7'd80, 5'd25);
    send_item(tcce_pkg::OP_SET, 8'h00, 7'd79, 5'd5);
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_TAB, 7'd0, 5'd0);     // tab past last column
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_BS, 7'd0, 5'd0);      // back to row above
    send_item(tcce_pkg::OP_CLEAR, 8'h00, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_SET, 8'h00, 7'd0, 5'd24);
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_LF, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_SET, 8'h00, 7'd72, 5'd3);
    send_item(tcce_pkg::OP_WRITE, tcce_pkg::CH_TAB, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_WRITE, 8'h7E, 7'd0, 5'd0);
    send_item(tcce_pkg::OP_SET, 8'h00, 7'd0, 5'd0);
    drain();

    run_phase(230, 8, 63, 8'd7, 8'hFF);
    run_phase(230, 63, 8, 8'd0, 8'h00);
    run_phase(120, 0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)));

    // long receiver stall with the sender pushing, then a full pause
    write_reg(tcce_pkg::CFG_TAB_ORIGIN, 8'($urandom_range(255)));
    write_reg(tcce_pkg::CFG_TEXT_ATTR, 8'($urandom_range(255)));
    fork
      hold_receiver(300);
    join_none
    repeat (70) send_random();
    drain();
    repeat (30) send_random();
    drain();

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/tcce_pkg.sv
design/tcce_in_reg.sv
design/tcce_cursor.sv
design/text_console_cursor_engine.sv
design/tcce_checker.sv
bench/tb.sv
